// ----- src/c16x_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c16x_pkg
// Shared types, opcodes and helpers for the 16-bit execute step.
// ----------------------------------------------------------------------------
package c16x_pkg;

    localparam int DATA_WORDS_DEF = 1024;
    localparam int MEM_ADDR_W     = 10;
    localparam logic [15:0] PC_RESET = 16'd1;

    typedef enum logic [3:0] {
        OP_BEQ   = 4'h0,
        OP_BNE   = 4'h1,
        OP_BLT   = 4'h2,
        OP_BGT   = 4'h3,
        OP_ADDI  = 4'h4,
        OP_MULI  = 4'h5,
        OP_LOAD  = 4'h6,
        OP_STORE = 4'h7,
        OP_SLLI  = 4'h8,
        OP_SUB   = 4'h9,
        OP_SUBI  = 4'hA,
        OP_JUMP  = 4'hB,
        OP_ADD   = 4'hC,
        OP_MUL   = 4'hD,
        OP_AND   = 4'hE,
        OP_HALT  = 4'hF
    } op_t;

    typedef struct packed {
        logic        taken;
        logic        reg_we;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        logic [15:0] next_pc;
        logic        halt;
        logic        is_load;
        logic        is_store;
        logic [15:0] mem_sum;
    } exec_t;

    function automatic logic [15:0] sext6(input logic [5:0] v);
        return {{10{v[5]}}, v};
    endfunction

    function automatic logic [15:0] sext12(input logic [11:0] v);
        return {{4{v[11]}}, v};
    endfunction

endpackage

// ----- src/c16x_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c16x_alu
// Decode and execute one instruction: branch test, arithmetic, shift,
// next program counter and the unreduced memory address sum.
// ----------------------------------------------------------------------------
module c16x_alu
    import c16x_pkg::*;
(
    input  logic [15:0] instr,
    input  logic [15:0] a,
    input  logic [15:0] b,
    input  logic [15:0] pc,
    output exec_t       ex
);

    always_comb
    begin
        op_t         op;
        logic [15:0] imm6;
        logic [15:0] imm12;
        logic [15:0] pc_inc;
        logic [15:0] mul_b;
        logic [31:0] prod;
        logic [15:0] offset;

        op     = op_t'(instr[15:12]);
        imm6   = sext6(instr[5:0]);
        imm12  = sext12(instr[11:0]);
        pc_inc = pc + 16'd1;
        mul_b  = (op == OP_MULI) ? imm6 : b;
        prod   = a * mul_b;
        ex     = '0;

        case (op)
            OP_BEQ:   ex.taken = (a == b);
            OP_BNE:   ex.taken = (a != b);
            OP_BLT:   ex.taken = ($signed(a) < $signed(b));
            OP_BGT:   ex.taken = ($signed(a) > $signed(b));
            OP_ADDI:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[8:6];
                ex.reg_val = a + imm6;
            end
            OP_MULI:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[8:6];
                ex.reg_val = prod[15:0];
            end
            OP_SUBI:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[8:6];
                ex.reg_val = a - imm6;
            end
            OP_SLLI:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[8:6];
                ex.reg_val = (imm6[5:4] == 2'b00) ? (a << imm6[3:0]) : 16'd0;
            end
            OP_LOAD:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[8:6];
                ex.is_load = 1'b1;
            end
            OP_STORE: ex.is_store = 1'b1;
            OP_SUB:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[5:3];
                ex.reg_val = a - b;
            end
            OP_ADD:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[5:3];
                ex.reg_val = a + b;
            end
            OP_MUL:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[5:3];
                ex.reg_val = prod[15:0];
            end
            OP_AND:
            begin
                ex.reg_we  = 1'b1;
                ex.reg_idx = instr[5:3];
                ex.reg_val = a & b;
            end
            OP_JUMP:  ex.taken = 1'b1;
            OP_HALT:  ex.halt  = 1'b1;
            default:  ex.halt  = 1'b0;
        endcase

        offset     = (op == OP_JUMP) ? imm12 : imm6;
        ex.next_pc = ex.taken ? (pc_inc + offset) : pc_inc;
        ex.mem_sum = a + imm6;
    end

endmodule

// ----- src/c16x_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c16x_regfile
// Eight 16-bit registers, one write port, two registered read ports with
// write-through of a same-cycle write.
// ----------------------------------------------------------------------------
module c16x_regfile
    import c16x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [2:0]  rd_addr_a,
    input  logic [2:0]  rd_addr_b,
    output logic [15:0] rd_data_a,
    output logic [15:0] rd_data_b,
    input  logic        wr_en,
    input  logic [2:0]  wr_addr,
    input  logic [15:0] wr_data
);

    logic [15:0] regs_reg [8];
    logic [15:0] rd_a_reg;
    logic [15:0] rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            regs_reg[wr_addr] <= wr_data;
        end
    end

    // forward the write that lands on the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= (wr_en && wr_addr == rd_addr_a) ? wr_data : regs_reg[rd_addr_a];
            rd_b_reg <= (wr_en && wr_addr == rd_addr_b) ? wr_data : regs_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- src/c16x_dmem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c16x_dmem
// Data memory with one write port, one registered read port and a zeroing
// sweep of every word after reset.
// ----------------------------------------------------------------------------
module c16x_dmem
    import c16x_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(DATA_WORDS)-1:0] wr_addr,
    input  logic [15:0]                   wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DATA_WORDS)-1:0] rd_addr,
    output logic [15:0]                   rd_data,
    output logic                          clear_busy
);

    localparam int AW = $clog2(DATA_WORDS);

    logic [15:0]   words_reg [DATA_WORDS];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] clr_idx_reg;
    logic          clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_idx_reg == AW'(DATA_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            words_reg[clr_idx_reg] <= '0;
        end
        else if (wr_en)
        begin
            words_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= words_reg[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ----- src/cpu16_execute_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu16_execute_step
// Execute step of a small 16-bit processor: program counter, eight
// registers and a word-addressed data memory, one result per instruction.
// ----------------------------------------------------------------------------
// Branches, jumps, register and immediate arithmetic and halt complete in
// PH_EXEC, so such instructions stream at one per clock while out_stall is
// low. Loads and stores step through PH_EXEC, PH_ADDR and PH_DATA: the
// address is reduced modulo DATA_WORDS by a reciprocal multiply and a
// registered back-multiply, and the data memory read port is registered. A
// register written by one instruction is forwarded to the next, so no stall
// is needed for dependencies. After reset in_stall stays high while the data
// memory is swept to zero. Once a halt has executed, every later instruction
// returns the current pc with halted set and changes nothing.
module cpu16_execute_step
    import c16x_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic        halted,
    output logic        branch_taken,
    output logic        reg_written,
    output logic [2:0]  reg_index,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [9:0]  mem_address,
    output logic [15:0] mem_value
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [31:0] RECIP =
        32'((64'd4294967296 + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS));

    typedef enum logic [1:0] {
        PH_EXEC,
        PH_ADDR,
        PH_DATA
    } phase_t;

    phase_t      phase_reg;
    logic        e_valid_reg;
    logic [15:0] e_instr_reg;
    logic [15:0] pc_reg;
    logic        halted_reg;
    logic [47:0] prod_reg;
    logic [15:0] addr_reg;

    logic        out_valid_reg;
    logic [15:0] next_pc_reg;
    logic        halted_out_reg;
    logic        taken_reg;
    logic        reg_written_reg;
    logic [2:0]  reg_index_reg;
    logic [15:0] reg_value_reg;
    logic        mem_written_reg;
    logic [9:0]  mem_address_reg;
    logic [15:0] mem_value_reg;

    exec_t       ex;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic        clr_busy;
    logic [15:0] dm_rdata;
    logic        is_mem;
    logic        e_done;
    logic        out_free;
    logic        e_fire;
    logic        in_accept;
    logic [47:0] prod_next;
    logic [32:0] qd;
    logic [15:0] addr_calc;
    logic        rf_we;
    logic [15:0] rf_wdata;
    logic        dm_rd_en;
    logic        dm_we;

    c16x_alu u_alu
    (
        .instr (e_instr_reg),
        .a     (op_a),
        .b     (op_b),
        .pc    (pc_reg),
        .ex    (ex)
    );

    c16x_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr_a (instr[11:9]),
        .rd_addr_b (instr[8:6]),
        .rd_data_a (op_a),
        .rd_data_b (op_b),
        .wr_en     (rf_we),
        .wr_addr   (ex.reg_idx),
        .wr_data   (rf_wdata)
    );

    c16x_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (dm_we),
        .wr_addr    (addr_reg[AW-1:0]),
        .wr_data    (op_b),
        .rd_en      (dm_rd_en),
        .rd_addr    (addr_calc[AW-1:0]),
        .rd_data    (dm_rdata),
        .clear_busy (clr_busy)
    );

    assign is_mem    = ex.is_load || ex.is_store;
    assign e_done    = (phase_reg == PH_DATA)
                    || (phase_reg == PH_EXEC && (halted_reg || !is_mem));
    assign out_free  = !out_valid_reg || !out_stall;
    assign e_fire    = e_valid_reg && e_done && out_free;
    assign in_stall  = clr_busy || (e_valid_reg && !e_fire);
    assign in_accept = in_valid && !in_stall;

    // address modulo DATA_WORDS: quotient by reciprocal, then subtract q * DATA_WORDS
    assign prod_next = 48'(ex.mem_sum) * 48'(RECIP);
    assign qd        = 33'(prod_reg[47:32]) * 33'(DATA_WORDS);
    assign addr_calc = 16'(33'(ex.mem_sum) - qd);

    assign rf_we    = e_fire && !halted_reg && ex.reg_we;
    assign rf_wdata = ex.is_load ? dm_rdata : ex.reg_val;
    assign dm_rd_en = e_valid_reg && (phase_reg == PH_ADDR) && ex.is_load;
    assign dm_we    = e_fire && !halted_reg && ex.is_store;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_EXEC;
            e_valid_reg     <= 1'b0;
            e_instr_reg     <= '0;
            pc_reg          <= PC_RESET;
            halted_reg      <= 1'b0;
            prod_reg        <= '0;
            addr_reg        <= '0;
            out_valid_reg   <= 1'b0;
            next_pc_reg     <= '0;
            halted_out_reg  <= 1'b0;
            taken_reg       <= 1'b0;
            reg_written_reg <= 1'b0;
            reg_index_reg   <= '0;
            reg_value_reg   <= '0;
            mem_written_reg <= 1'b0;
            mem_address_reg <= '0;
            mem_value_reg   <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                e_valid_reg <= 1'b1;
                e_instr_reg <= instr;
            end
            else if (e_fire)
            begin
                e_valid_reg <= 1'b0;
            end

            if (e_fire)
            begin
                phase_reg <= PH_EXEC;
            end
            else if (e_valid_reg && phase_reg == PH_EXEC && !halted_reg && is_mem)
            begin
                phase_reg <= PH_ADDR;
                prod_reg  <= prod_next;
            end
            else if (e_valid_reg && phase_reg == PH_ADDR)
            begin
                phase_reg <= PH_DATA;
                addr_reg  <= addr_calc;
            end

            if (e_fire)
            begin
                out_valid_reg <= 1'b1;
                if (halted_reg)
                begin
                    next_pc_reg     <= pc_reg;
                    halted_out_reg  <= 1'b1;
                    taken_reg       <= 1'b0;
                    reg_written_reg <= 1'b0;
                    reg_index_reg   <= '0;
                    reg_value_reg   <= '0;
                    mem_written_reg <= 1'b0;
                    mem_address_reg <= '0;
                    mem_value_reg   <= '0;
                end
                else
                begin
                    pc_reg          <= ex.next_pc;
                    halted_reg      <= ex.halt;
                    next_pc_reg     <= ex.next_pc;
                    halted_out_reg  <= ex.halt;
                    taken_reg       <= ex.taken;
                    reg_written_reg <= ex.reg_we;
                    reg_index_reg   <= ex.reg_idx;
                    reg_value_reg   <= ex.reg_we ? rf_wdata : 16'd0;
                    mem_written_reg <= ex.is_store;
                    mem_address_reg <= is_mem ? addr_reg[MEM_ADDR_W-1:0] : '0;
                    mem_value_reg   <= ex.is_load ? dm_rdata : (ex.is_store ? op_b : 16'd0);
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = next_pc_reg;
    assign halted       = halted_out_reg;
    assign branch_taken = taken_reg;
    assign reg_written  = reg_written_reg;
    assign reg_index    = reg_index_reg;
    assign reg_value    = reg_value_reg;
    assign mem_written  = mem_written_reg;
    assign mem_address  = mem_address_reg;
    assign mem_value    = mem_value_reg;

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared after halt");

    a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !e_fire |=> $stable(pc_reg))
        else $error("pc changed without a completed instruction");

    a_mem_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        dm_we |-> (phase_reg == PH_DATA) && !clr_busy)
        else $error("data memory written outside the final store cycle");

    a_phase_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_EXEC) |-> (e_valid_reg && !halted_reg && is_mem))
        else $error("memory phase without a live load or store");

endmodule
